// ===== hdl/dhm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhm_pkg
// Shared types and constants of the depth hypothesis merge core.
// ----------------------------------------------------------------------------
package dhm_pkg;

    localparam int DEPTH_W = 16;
    localparam int CONF_W  = 16;
    localparam int INV_W   = 32;
    localparam int INV_NW  = 33;
    localparam int PROD_W  = 48;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [2:0] ST_SKIP      = 3'd0;
    localparam logic [2:0] ST_NO_CAND   = 3'd1;
    localparam logic [2:0] ST_LOW_CONF  = 3'd2;
    localparam logic [2:0] ST_BAD_MEAN  = 3'd3;
    localparam logic [2:0] ST_SPREAD    = 3'd4;
    localparam logic [2:0] ST_PRIOR     = 3'd5;
    localparam logic [2:0] ST_RECOVERED = 3'd6;

    localparam logic [CFG_AW-1:0] CFG_MIN_CONF       = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_PRIOR      = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MAX_CONS_PRIOR = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_MAX_SPREAD     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_MIN_COUNT      = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_HYP_COUNT      = 3'd5;

    localparam logic [15:0] RST_MIN_CONF       = 16'd0;
    localparam logic [15:0] RST_MAX_PRIOR      = 16'd1024;
    localparam logic [15:0] RST_MAX_CONS_PRIOR = 16'd1024;
    localparam logic [15:0] RST_MAX_SPREAD     = 16'd256;
    localparam logic [2:0]  RST_MIN_COUNT      = 3'd2;
    localparam logic [1:0]  RST_HYP_COUNT      = 2'd3;

    typedef struct packed {
        logic               early;
        logic [2:0]         early_status;
        logic               cons;
        logic               too_few;
        logic [CONF_W-1:0]  cmin;
        logic [DEPTH_W-1:0] cur_d;
        logic [CONF_W-1:0]  cur_c;
        logic [DEPTH_W-1:0] prior;
        logic [DEPTH_W-1:0] nearest;
        logic               surf;
    } t_ctx;

    typedef struct packed {
        logic [15:0] max_spread;
        logic [15:0] max_prior;
        logic [15:0] max_cons_prior;
    } t_cfg;

    typedef struct packed {
        logic              elig;
        logic [CONF_W-1:0] conf;
        logic [INV_W-1:0]  inv;
        logic [PROD_W-1:0] prod;
    } t_lane;

endpackage

// ===== hdl/dhm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhm_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module dhm_div #(
    parameter int NW = 33,
    parameter int DW = 16,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic [NW-1:0] r_vld;
    logic [DW-1:0] r_den [NW];
    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_rem [NW];
    logic [PW-1:0] r_pay [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          w_vld_in;
        logic [DW-1:0] w_den_in;
        logic [NW-1:0] w_num_in;
        logic [DW-1:0] w_rem_in;
        logic [PW-1:0] w_pay_in;
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_q;

        if (k == 0) begin : g_first
            assign w_vld_in = i_valid;
            assign w_den_in = i_den;
            assign w_num_in = i_num;
            assign w_rem_in = '0;
            assign w_pay_in = i_pay;
        end else begin : g_next
            assign w_vld_in = r_vld[k-1];
            assign w_den_in = r_den[k-1];
            assign w_num_in = r_num[k-1];
            assign w_rem_in = r_rem[k-1];
            assign w_pay_in = r_pay[k-1];
        end

        assign w_trial = {w_rem_in, w_num_in[NW-1]};
        assign w_q     = w_trial >= {1'b0, w_den_in};
        assign w_diff  = w_trial - {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_in;
            end
            r_den[k] <= w_den_in;
            r_num[k] <= {w_num_in[NW-2:0], w_q};
            r_rem[k] <= w_q ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_pay[k] <= w_pay_in;
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_num[NW-1];
    assign o_pay   = r_pay[NW-1];

endmodule

// ===== hdl/dhm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhm_lane
// One hypothesis lane: inverse depth by division and confidence-weighted term.
// ----------------------------------------------------------------------------
module dhm_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_elig,
    input  logic [dhm_pkg::DEPTH_W-1:0] i_depth,
    input  logic [dhm_pkg::CONF_W-1:0]  i_conf,
    output logic                        o_valid,
    output dhm_pkg::t_lane              o_lane
);

    localparam int PW = dhm_pkg::CONF_W + 1;

    logic                        w_div_vld;
    logic [dhm_pkg::INV_NW-1:0]  w_quo;
    logic [PW-1:0]               w_pay;
    logic [dhm_pkg::INV_W-1:0]   w_inv;
    logic                        w_elig;
    logic [dhm_pkg::CONF_W-1:0]  w_conf;
    logic                        r_vld;
    dhm_pkg::t_lane              r_lane;

    dhm_div #(
        .NW (dhm_pkg::INV_NW),
        .DW (dhm_pkg::DEPTH_W),
        .PW (PW)
    ) u_inv_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_num   ({1'b1, {dhm_pkg::INV_W{1'b0}}}),
        .i_den   (i_depth),
        .i_pay   ({i_elig, i_conf}),
        .o_valid (w_div_vld),
        .o_quo   (w_quo),
        .o_pay   (w_pay)
    );

    // depth of one saturates to all ones
    assign w_inv  = w_quo[dhm_pkg::INV_W] ? {dhm_pkg::INV_W{1'b1}} : w_quo[dhm_pkg::INV_W-1:0];
    assign w_elig = w_pay[PW-1];
    assign w_conf = w_pay[dhm_pkg::CONF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_div_vld;
        end
        r_lane.elig <= w_elig;
        r_lane.conf <= w_conf;
        r_lane.inv  <= w_inv;
        r_lane.prod <= w_elig ? w_inv * w_conf : '0;
    end

    assign o_valid = r_vld;
    assign o_lane  = r_lane;

endmodule

// ===== hdl/dhm_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhm_merge
// Combines lane results: weighted mean, spread check, merged depth, prior check.
// ----------------------------------------------------------------------------
module dhm_merge #(
    parameter int H = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  dhm_pkg::t_lane [H-1:0]        i_lane,
    input  dhm_pkg::t_ctx                 i_ctx,
    input  dhm_pkg::t_cfg                 i_cfg,
    output logic                          o_valid,
    output logic [dhm_pkg::DEPTH_W-1:0]   o_depth,
    output logic [dhm_pkg::CONF_W-1:0]    o_conf,
    output logic [2:0]                    o_status,
    output logic                          o_cons,
    output logic                          o_too_few,
    output logic                          o_surf
);

    localparam int SW    = $clog2(H + 1);
    localparam int CSW   = dhm_pkg::CONF_W + SW;
    localparam int WSW   = dhm_pkg::PROD_W + SW;
    localparam int SCSW  = 32 + CSW;
    localparam int RPW   = SCSW + 16;
    localparam int R01W  = RPW + 17;
    localparam int RHSW  = R01W + 33;
    localparam int TW    = 80;
    localparam int LHSW  = TW + SW;
    localparam int DNW   = 33;

    typedef struct packed {
        dhm_pkg::t_ctx              ctx;
        logic [H-1:0]               elig;
        logic [H-1:0][15:0]         conf;
        logic [H-1:0][31:0]         inv;
        logic [CSW-1:0]             csum;
    } t_mp;

    typedef struct packed {
        dhm_pkg::t_ctx ctx;
        logic          bad;
        logic          sfail;
    } t_dp;

    // sums over lanes
    logic [WSW-1:0] w_wsum;
    logic [CSW-1:0] w_csum;
    t_mp            w_mp_in;

    always_comb begin
        w_wsum = '0;
        w_csum = '0;
        for (int i = 0; i < H; i++) begin
            w_wsum = w_wsum + WSW'(i_lane[i].prod);
            if (i_lane[i].elig) begin
                w_csum = w_csum + CSW'(i_lane[i].conf);
            end
            w_mp_in.elig[i] = i_lane[i].elig;
            w_mp_in.conf[i] = i_lane[i].conf;
            w_mp_in.inv[i]  = i_lane[i].inv;
        end
        w_mp_in.ctx  = i_ctx;
        w_mp_in.csum = w_csum;
    end

    logic           r_m_vld;
    logic [WSW-1:0] r_m_wsum;
    t_mp            r_m_mp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= i_valid;
        end
        r_m_wsum <= w_wsum;
        r_m_mp   <= w_mp_in;
    end

    logic           w_mdiv_vld;
    logic [WSW-1:0] w_mquo;
    t_mp            w_mdiv_mp;

    dhm_div #(
        .NW (WSW),
        .DW (CSW),
        .PW ($bits(t_mp))
    ) u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_vld),
        .i_num   (r_m_wsum),
        .i_den   (r_m_mp.csum),
        .i_pay   (r_m_mp),
        .o_valid (w_mdiv_vld),
        .o_quo   (w_mquo),
        .o_pay   (w_mdiv_mp)
    );

    // spread check pipeline
    logic               r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;
    t_mp                r_a_mp, r_b_mp, r_c_mp, r_d_mp;
    dhm_pkg::t_ctx      r_e_ctx, r_f_ctx, r_g_ctx;
    logic [31:0]        r_a_mean, r_b_mean, r_c_mean, r_d_mean, r_e_mean, r_f_mean, r_g_mean;
    logic               r_a_bad, r_b_bad, r_c_bad, r_d_bad, r_e_bad, r_f_bad, r_g_bad;
    logic [H-1:0][31:0] r_b_df;
    logic [63:0]        r_b_msq, r_c_msq;
    logic [31:0]        r_b_ssq;
    logic [H-1:0][63:0] r_c_dsq;
    logic [SCSW-1:0]    r_c_scs;
    logic [H-1:0][47:0] r_d_tlo, r_d_thi;
    logic [3:0][RPW-1:0] r_d_rp;
    logic [H-1:0][TW-1:0] r_e_term;
    logic [R01W-1:0]    r_e_r01, r_e_r23;
    logic [LHSW-1:0]    r_f_lhs;
    logic [RHSW-1:0]    r_f_rhs;
    logic               r_g_sfail;
    logic [LHSW-1:0]    w_lhs;

    always_comb begin
        w_lhs = '0;
        for (int i = 0; i < H; i++) begin
            w_lhs = w_lhs + LHSW'(r_e_term[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            r_a_vld <= w_mdiv_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
        r_a_mp   <= w_mdiv_mp;
        r_a_mean <= w_mquo[31:0];
        r_a_bad  <= (w_mdiv_mp.csum == '0) || (w_mquo == '0);

        r_b_mp   <= r_a_mp;
        r_b_mean <= r_a_mean;
        r_b_bad  <= r_a_bad;
        for (int i = 0; i < H; i++) begin
            r_b_df[i] <= (r_a_mp.inv[i] > r_a_mean) ? r_a_mp.inv[i] - r_a_mean
                                                     : r_a_mean - r_a_mp.inv[i];
        end
        r_b_msq  <= r_a_mean * r_a_mean;
        r_b_ssq  <= i_cfg.max_spread * i_cfg.max_spread;

        r_c_mp   <= r_b_mp;
        r_c_mean <= r_b_mean;
        r_c_bad  <= r_b_bad;
        for (int i = 0; i < H; i++) begin
            r_c_dsq[i] <= r_b_df[i] * r_b_df[i];
        end
        r_c_msq  <= r_b_msq;
        r_c_scs  <= r_b_ssq * r_b_mp.csum;

        r_d_mp   <= r_c_mp;
        r_d_mean <= r_c_mean;
        r_d_bad  <= r_c_bad;
        for (int i = 0; i < H; i++) begin
            r_d_tlo[i] <= r_c_mp.conf[i] * r_c_dsq[i][31:0];
            r_d_thi[i] <= r_c_mp.conf[i] * r_c_dsq[i][63:32];
        end
        for (int j = 0; j < 4; j++) begin
            r_d_rp[j] <= r_c_scs * r_c_msq[16*j +: 16];
        end

        r_e_ctx  <= r_d_mp.ctx;
        r_e_mean <= r_d_mean;
        r_e_bad  <= r_d_bad;
        for (int i = 0; i < H; i++) begin
            r_e_term[i] <= r_d_mp.elig[i] ? ({r_d_thi[i], 32'b0} + TW'(r_d_tlo[i])) : '0;
        end
        r_e_r01  <= R01W'(r_d_rp[0]) + (R01W'(r_d_rp[1]) << 16);
        r_e_r23  <= R01W'(r_d_rp[2]) + (R01W'(r_d_rp[3]) << 16);

        r_f_ctx  <= r_e_ctx;
        r_f_mean <= r_e_mean;
        r_f_bad  <= r_e_bad;
        r_f_lhs  <= w_lhs;
        r_f_rhs  <= RHSW'(r_e_r01) + (RHSW'(r_e_r23) << 32);

        r_g_ctx   <= r_f_ctx;
        r_g_mean  <= r_f_mean;
        r_g_bad   <= r_f_bad;
        r_g_sfail <= RHSW'({r_f_lhs, 24'b0}) > r_f_rhs;
    end

    // merged depth: round-half-up of 2^32 / mean
    t_dp            w_dp_in;
    logic           w_ddiv_vld;
    logic [DNW-1:0] w_dquo;
    t_dp            w_ddiv_dp;

    assign w_dp_in.ctx   = r_g_ctx;
    assign w_dp_in.bad   = r_g_bad;
    assign w_dp_in.sfail = r_g_sfail;

    dhm_div #(
        .NW (DNW),
        .DW (32),
        .PW ($bits(t_dp))
    ) u_depth_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_g_vld),
        .i_num   ({1'b1, 32'b0} + DNW'(r_g_mean >> 1)),
        .i_den   (r_g_mean),
        .i_pay   (w_dp_in),
        .o_valid (w_ddiv_vld),
        .o_quo   (w_dquo),
        .o_pay   (w_ddiv_dp)
    );

    logic [15:0] w_d, w_p, w_allowed;

    assign w_d = (w_dquo[DNW-1:16] != '0) ? 16'hFFFF : w_dquo[15:0];
    assign w_p = w_ddiv_dp.ctx.cons ? w_ddiv_dp.ctx.prior : w_ddiv_dp.ctx.nearest;
    assign w_allowed = !w_ddiv_dp.ctx.cons ? i_cfg.max_prior :
                       (i_cfg.max_cons_prior > i_cfg.max_prior) ? i_cfg.max_cons_prior
                                                                 : i_cfg.max_prior;

    logic          r_h_vld, r_i_vld, r_j_vld;
    t_dp           r_h_dp, r_i_dp;
    logic [15:0]   r_h_d, r_h_p, r_h_allowed, r_h_diff, r_i_d;
    logic          r_i_pfail;
    logic [15:0]   r_j_depth, r_j_conf;
    logic [2:0]    r_j_status;
    logic          r_j_cons, r_j_too_few, r_j_surf;
    logic [31:0]   w_lim;
    logic [2:0]    w_status;

    assign w_lim = r_h_allowed * r_h_p;

    always_comb begin
        if (r_i_dp.ctx.early) begin
            w_status = r_i_dp.ctx.early_status;
        end else if (r_i_dp.bad) begin
            w_status = dhm_pkg::ST_BAD_MEAN;
        end else if (r_i_dp.ctx.cons && r_i_dp.sfail) begin
            w_status = dhm_pkg::ST_SPREAD;
        end else if (r_i_pfail) begin
            w_status = dhm_pkg::ST_PRIOR;
        end else begin
            w_status = dhm_pkg::ST_RECOVERED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
        end else begin
            r_h_vld <= w_ddiv_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
        end
        r_h_dp      <= w_ddiv_dp;
        r_h_d       <= w_d;
        r_h_p       <= w_p;
        r_h_allowed <= w_allowed;
        r_h_diff    <= (w_d > w_p) ? w_d - w_p : w_p - w_d;

        r_i_dp    <= r_h_dp;
        r_i_d     <= r_h_d;
        r_i_pfail <= (r_h_p == '0) || ({4'b0, r_h_diff, 12'b0} > w_lim);

        r_j_status  <= w_status;
        r_j_too_few <= !r_i_dp.ctx.early && r_i_dp.ctx.too_few;
        r_j_cons    <= r_i_dp.ctx.cons && ((w_status == dhm_pkg::ST_PRIOR) ||
                                           (w_status == dhm_pkg::ST_RECOVERED));
        r_j_surf    <= r_i_dp.ctx.cons && r_i_dp.ctx.surf &&
                       (w_status == dhm_pkg::ST_RECOVERED);
        if (w_status == dhm_pkg::ST_RECOVERED) begin
            r_j_depth <= r_i_d;
            r_j_conf  <= r_i_dp.ctx.cmin;
        end else begin
            r_j_depth <= r_i_dp.ctx.cur_d;
            r_j_conf  <= r_i_dp.ctx.cur_c;
        end
    end

    assign o_valid   = r_j_vld;
    assign o_depth   = r_j_depth;
    assign o_conf    = r_j_conf;
    assign o_status  = r_j_status;
    assign o_cons    = r_j_cons;
    assign o_too_few = r_j_too_few;
    assign o_surf    = r_j_surf;

endmodule

// ===== hdl/depth_hypothesis_merge_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_hypothesis_merge_core
// Per-pixel merge of up to three depth hypotheses into a gap pixel.
// ----------------------------------------------------------------------------
// A pixel transaction is taken at each rising edge with i_start high and o_busy
// low; o_busy stays low, so one pixel can be taken every clock cycle.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata with
// i_cfg_we high, by the user only while no pixel is in flight (not enforced).
// Each result shows on the o_ result ports for one cycle with o_valid high,
// in input order, after passing the input register, the lanes and the merge stages.
// The path runs through three pipelined dividers, one quotient bit per stage:
// the per-lane inverse depth (33 stages), the weighted mean (50 stages) and
// the rounded merged depth (33 stages). Throughput is one pixel per cycle.
// Synchronous active-low reset empties the pipeline and loads the default
// register values; pixels in flight are dropped.
// The receiver cannot stall: results are not held back.
// ----------------------------------------------------------------------------
module depth_hypothesis_merge_core #(
    parameter int HYPOTHESES = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_cfg_we,
    input  logic [dhm_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [dhm_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  logic                        i_in_gap,
    input  logic [15:0]                 i_current_depth,
    input  logic [15:0]                 i_current_confidence,
    input  logic [15:0]                 i_prior_depth,
    input  logic [15:0]                 i_nearest_prior_depth,
    input  logic                        i_surface_prior_flag,
    input  logic [15:0]                 i_cand_depth_a,
    input  logic [15:0]                 i_cand_depth_b,
    input  logic [15:0]                 i_cand_depth_c,
    input  logic [15:0]                 i_cand_conf_a,
    input  logic [15:0]                 i_cand_conf_b,
    input  logic [15:0]                 i_cand_conf_c,
    output logic                        o_valid,
    output logic [15:0]                 o_new_depth,
    output logic [15:0]                 o_new_confidence,
    output logic [2:0]                  o_status,
    output logic                        o_consensus_used,
    output logic                        o_too_few_hypotheses,
    output logic                        o_surface_prior_accepted
);

    localparam int H    = HYPOTHESES;
    localparam int CW   = $clog2(H + 1);
    localparam int DLY  = dhm_pkg::INV_NW + 1;

    // configuration registers
    logic [15:0] r_min_conf, r_max_prior, r_max_cons_prior, r_max_spread;
    logic [2:0]  r_min_count;
    logic [1:0]  r_hyp_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_conf       <= dhm_pkg::RST_MIN_CONF;
            r_max_prior      <= dhm_pkg::RST_MAX_PRIOR;
            r_max_cons_prior <= dhm_pkg::RST_MAX_CONS_PRIOR;
            r_max_spread     <= dhm_pkg::RST_MAX_SPREAD;
            r_min_count      <= dhm_pkg::RST_MIN_COUNT;
            r_hyp_count      <= dhm_pkg::RST_HYP_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dhm_pkg::CFG_MIN_CONF:       r_min_conf       <= i_cfg_wdata;
                dhm_pkg::CFG_MAX_PRIOR:      r_max_prior      <= i_cfg_wdata;
                dhm_pkg::CFG_MAX_CONS_PRIOR: r_max_cons_prior <= i_cfg_wdata;
                dhm_pkg::CFG_MAX_SPREAD:     r_max_spread     <= i_cfg_wdata;
                dhm_pkg::CFG_MIN_COUNT:      r_min_count      <= i_cfg_wdata[2:0];
                dhm_pkg::CFG_HYP_COUNT:      r_hyp_count      <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic        r_in_vld;
    logic        r_gap, r_surf;
    logic [15:0] r_cur_d, r_cur_c, r_prior, r_nearest;
    logic [15:0] r_cd [3];
    logic [15:0] r_cc [3];

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start && !o_busy;
        end
        r_gap     <= i_in_gap;
        r_surf    <= i_surface_prior_flag;
        r_cur_d   <= i_current_depth;
        r_cur_c   <= i_current_confidence;
        r_prior   <= i_prior_depth;
        r_nearest <= i_nearest_prior_depth;
        r_cd[0]   <= i_cand_depth_a;
        r_cd[1]   <= i_cand_depth_b;
        r_cd[2]   <= i_cand_depth_c;
        r_cc[0]   <= i_cand_conf_a;
        r_cc[1]   <= i_cand_conf_b;
        r_cc[2]   <= i_cand_conf_c;
    end

    // eligibility and early decisions
    logic [1:0]    w_nuse;
    logic [2:0]    w_need;
    logic [H-1:0]  w_present, w_elig;
    logic [CW-1:0] w_count;
    logic [15:0]   w_cmin;
    logic          w_skip, w_cons;
    dhm_pkg::t_ctx w_ctx;

    assign w_nuse = (r_hyp_count > 2'(H)) ? 2'(H) : r_hyp_count;
    assign w_need = (r_min_count < 3'd2) ? 3'd2 : r_min_count;

    always_comb begin
        w_count = '0;
        w_cmin  = 16'hFFFF;
        for (int i = 0; i < H; i++) begin
            w_present[i] = (2'(i) < w_nuse) && (r_cd[i] != '0);
            w_elig[i]    = w_present[i] && (r_cc[i] >= r_min_conf);
            w_count      = w_count + CW'(w_elig[i]);
            if (w_elig[i] && (r_cc[i] < w_cmin)) begin
                w_cmin = r_cc[i];
            end
        end
    end

    assign w_skip = !r_gap || (r_cur_d != '0) || (w_nuse == '0);
    assign w_cons = 3'(w_count) >= w_need;

    always_comb begin
        w_ctx.early        = 1'b1;
        w_ctx.early_status = dhm_pkg::ST_SKIP;
        if (w_skip) begin
            w_ctx.early_status = dhm_pkg::ST_SKIP;
        end else if (w_present == '0) begin
            w_ctx.early_status = dhm_pkg::ST_NO_CAND;
        end else if (w_count == '0) begin
            w_ctx.early_status = dhm_pkg::ST_LOW_CONF;
        end else begin
            w_ctx.early = 1'b0;
        end
        w_ctx.cons    = w_cons;
        w_ctx.too_few = (3'(w_nuse) >= w_need) && !w_cons;
        w_ctx.cmin    = w_cmin;
        w_ctx.cur_d   = r_cur_d;
        w_ctx.cur_c   = r_cur_c;
        w_ctx.prior   = r_prior;
        w_ctx.nearest = r_nearest;
        w_ctx.surf    = r_surf;
    end

    // context follows the lanes
    dhm_pkg::t_ctx r_ctx [DLY];

    always_ff @(posedge i_clk) begin
        r_ctx[0] <= w_ctx;
        for (int k = 1; k < DLY; k++) begin
            r_ctx[k] <= r_ctx[k-1];
        end
    end

    // lanes
    logic [H-1:0]           w_lane_vld;
    dhm_pkg::t_lane [H-1:0] w_lane;

    for (genvar i = 0; i < H; i++) begin : g_lane
        dhm_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_in_vld),
            .i_elig  (w_elig[i]),
            .i_depth (r_cd[i]),
            .i_conf  (r_cc[i]),
            .o_valid (w_lane_vld[i]),
            .o_lane  (w_lane[i])
        );
    end

    dhm_pkg::t_cfg w_cfg;

    assign w_cfg.max_spread     = r_max_spread;
    assign w_cfg.max_prior      = r_max_prior;
    assign w_cfg.max_cons_prior = r_max_cons_prior;

    dhm_merge #(
        .H (H)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_lane_vld[0]),
        .i_lane    (w_lane),
        .i_ctx     (r_ctx[DLY-1]),
        .i_cfg     (w_cfg),
        .o_valid   (o_valid),
        .o_depth   (o_new_depth),
        .o_conf    (o_new_confidence),
        .o_status  (o_status),
        .o_cons    (o_consensus_used),
        .o_too_few (o_too_few_hypotheses),
        .o_surf    (o_surface_prior_accepted)
    );

`ifndef NO_ASSERTIONS
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_vld == {H{w_lane_vld[0]}})
        else $error("lanes out of step");

    a_recovered_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == dhm_pkg::ST_RECOVERED) |-> o_new_depth != '0)
        else $error("recovered pixel with zero depth");

    a_surface_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_surface_prior_accepted |->
            o_consensus_used && (o_status == dhm_pkg::ST_RECOVERED))
        else $error("surface prior flag without consensus recovery");

    a_consensus_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_consensus_used |->
            (o_status == dhm_pkg::ST_PRIOR) || (o_status == dhm_pkg::ST_RECOVERED))
        else $error("consensus flag on an early status");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_consensus_used && o_too_few_hypotheses))
        else $error("consensus and too few hypotheses together");
`endif

endmodule
